// ===== rtl/core/scmc_pkg.sv =====
// Shared types and constants for the step-charging mode controller.
`timescale 1ns / 1ps
package scmc_pkg;

	localparam int MaxSteps = 8;
	localparam int IdxW     = 3;
	localparam int CntW     = 4;

	localparam logic [1:0] OP_SAMPLE = 2'd0;
	localparam logic [1:0] OP_RESET  = 2'd1;
	localparam logic [1:0] OP_WRITE  = 2'd2;

	localparam logic [0:0] REG_STEP_COUNT = 1'd0;
	localparam logic [0:0] REG_VOLT_GAP   = 1'd1;

	localparam logic [2:0] MODE_CC        = 3'd0;
	localparam logic [2:0] MODE_CC_ADJ    = 3'd1;
	localparam logic [2:0] MODE_CV_CHECK  = 3'd2;
	localparam logic [2:0] MODE_CV_PRESET = 3'd3;
	localparam logic [2:0] MODE_CV        = 3'd4;
	localparam logic [2:0] MODE_CV_ADJ    = 3'd5;
	localparam logic [2:0] MODE_CHANGE    = 3'd6;

	localparam logic [1:0] VM_NONE = 2'd0;
	localparam logic [1:0] VM_CC   = 2'd1;
	localparam logic [1:0] VM_CV   = 2'd2;

	typedef struct packed {
		logic [1:0]  op;
		logic        charging;
		logic        cool_or_cold;
		logic        demo_mode;
		logic        phm_active;
		logic [15:0] vbat_avg;
		logic [15:0] vbat_now;
		logic [15:0] input_current;
		logic [2:0]  entry_index;
		logic [63:0] entry_word;
	} item_t;

	typedef struct packed {
		logic        step_valid;
		logic [2:0]  step_index;
		logic [2:0]  mode;
		logic        charge_votes_on;
		logic [15:0] voltage_vote;
		logic [15:0] current_vote;
		logic [1:0]  vm_source;
	} res_t;

	typedef struct packed {
		logic            en;
		logic [IdxW-1:0] addr;
		logic [63:0]     data;
	} tbl_wr_t;

endpackage

// ===== rtl/core/step_charge_mode_controller.sv =====
// Top level of the step-charging mode controller: ports, config registers, packing.
//
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tuser op, tdata sample/table fields
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata step/mode/vote state
// cfg       in   cfg_we (no wait)              cfg_index, cfg_data
//
// Table write, reset, unknown ops, held or disqualifying samples, or no steps configured: accept, then result load.
// Monitor sample with a step held: table read, up to two compares on the one shared
// comparator, result load; moving to a next step adds another table read.
// First step selection: up to 8 entries scanned, one table read per entry scanned.
// arst_n clears the controller state; the table holds garbage until written.
// A result waiting on m_axis stalls only the final load of the next item.
`timescale 1ns / 1ps
module step_charge_mode_controller
	import scmc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// [0] charging, [1] cool_or_cold, [2] demo_mode, [3] phm_active,
	// [19:4] vbat_avg, [35:20] vbat_now, [51:36] input_current,
	// [54:52] entry_index, [118:55] entry_word, [119] zero
	input  logic [119:0] s_axis_tdata,
	// [1:0] op
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [0] step_valid, [3:1] step_index, [6:4] mode, [7] charge_votes_on,
	// [23:8] voltage_vote, [39:24] current_vote, [41:40] vm_source, [47:42] zero
	output logic [47:0]  m_axis_tdata,
	input  logic         cfg_we,
	input  logic [0:0]   cfg_index,
	input  logic [9:0]   cfg_data
);

	logic [3:0]      step_count_q;
	logic [9:0]      volt_gap_q;
	item_t           item;
	res_t            res;
	tbl_wr_t         wr;
	logic [IdxW-1:0] rd_addr;
	logic [63:0]     rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_count_q <= 4'd1;
			volt_gap_q   <= 10'd25;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_STEP_COUNT: step_count_q <= cfg_data[3:0];
				REG_VOLT_GAP:   volt_gap_q   <= cfg_data;
				default:        volt_gap_q   <= volt_gap_q;
			endcase
		end
	end

	assign item.op            = s_axis_tuser;
	assign item.charging      = s_axis_tdata[0];
	assign item.cool_or_cold  = s_axis_tdata[1];
	assign item.demo_mode     = s_axis_tdata[2];
	assign item.phm_active    = s_axis_tdata[3];
	assign item.vbat_avg      = s_axis_tdata[19:4];
	assign item.vbat_now      = s_axis_tdata[35:20];
	assign item.input_current = s_axis_tdata[51:36];
	assign item.entry_index   = s_axis_tdata[54:52];
	assign item.entry_word    = s_axis_tdata[118:55];

	assign m_axis_tdata = {6'b0, res.vm_source, res.current_vote, res.voltage_vote,
		res.charge_votes_on, res.mode, res.step_index, res.step_valid};

	scmc_table u_table (
		.clk     (clk),
		.wr      (wr),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	scmc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.item       (item),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.res        (res),
		.step_count (step_count_q),
		.volt_gap   (volt_gap_q),
		.wr         (wr),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data)
	);

endmodule

// ===== rtl/core/scmc_table.sv =====
// Step table memory: one write port, one registered read port.
`timescale 1ns / 1ps
module scmc_table
	import scmc_pkg::*;
(
	input  logic            clk,
	input  tbl_wr_t         wr,
	input  logic [IdxW-1:0] rd_addr,
	output logic [63:0]     rd_data
);

	logic [63:0] mem [MaxSteps];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== rtl/core/scmc_ctrl.sv =====
// Sequencer with one shared signed comparator: step scan and mode walk.
`timescale 1ns / 1ps
module scmc_ctrl
	import scmc_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  item_t           item,
	output logic            out_valid,
	input  logic            out_ready,
	output res_t            res,
	input  logic [3:0]      step_count,
	input  logic [9:0]      volt_gap,
	output tbl_wr_t         wr,
	output logic [IdxW-1:0] rd_addr,
	input  logic [63:0]     rd_data
);

	typedef enum logic [1:0] {S_IDLE, S_READ, S_EVAL, S_FIN} state_t;
	typedef enum logic [1:0] {PH_SCAN, PH_VOLT, PH_CURR, PH_CHOOSE} phase_t;

	state_t          state_q;
	phase_t          phase_q;
	logic [IdxW-1:0] addr_q;
	logic [15:0]     vavg_q;
	logic [15:0]     vnow_q;
	logic [15:0]     iin_q;
	logic            have_q;
	logic [IdxW-1:0] step_q;
	logic [2:0]      mode_q;
	logic            votes_q;
	logic [1:0]      vm_q;
	logic [15:0]     vvolt_q;
	logic [15:0]     vcurr_q;
	logic            out_valid_q;
	res_t            res_q;

	logic [CntW-1:0] n_steps;
	logic [CntW-1:0] next_idx;
	logic            next_ok;
	logic            scan_more;
	logic            accept;
	logic            cc_mode;
	logic [15:0]     fv;
	logic [15:0]     chg;
	logic [15:0]     ccx;
	logic [15:0]     cvx;
	logic [17:0]     cmp_a;
	logic [17:0]     cmp_b;
	logic            gt;

	assign fv  = rd_data[15:0];
	assign chg = rd_data[31:16];
	assign ccx = rd_data[47:32];
	assign cvx = rd_data[63:48];

	assign n_steps   = (step_count > CntW'(MaxSteps)) ? CntW'(MaxSteps) : step_count;
	assign scan_more = ({1'b0, addr_q} + CntW'(1)) < n_steps;
	assign next_idx  = {1'b0, step_q} + CntW'(1);
	assign next_ok   = next_idx < n_steps;
	assign cc_mode   = (mode_q == MODE_CC) || (mode_q == MODE_CC_ADJ);

	// shared compare unit
	always_comb begin
		case (phase_q)
			PH_SCAN: begin
				cmp_a = {2'b00, vavg_q};
				cmp_b = {2'b00, fv};
			end
			PH_VOLT: begin
				cmp_a = {2'b00, fv} - {8'b0, volt_gap};
				cmp_b = {2'b00, vnow_q};
			end
			default: begin
				cmp_a = {2'b00, cc_mode ? ccx : cvx};
				cmp_b = {2'b00, iin_q};
			end
		endcase
		gt = $signed(cmp_a) > $signed(cmp_b);
	end

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign wr.en     = accept && (item.op == OP_WRITE) &&
		({1'b0, item.entry_index} < CntW'(MaxSteps));
	assign wr.addr   = item.entry_index;
	assign wr.data   = item.entry_word;
	assign rd_addr   = addr_q;
	assign out_valid = out_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_SCAN;
			addr_q      <= '0;
			have_q      <= 1'b0;
			step_q      <= '0;
			mode_q      <= MODE_CC;
			votes_q     <= 1'b0;
			vm_q        <= VM_NONE;
			vvolt_q     <= '0;
			vcurr_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && (state_q != S_FIN)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						vavg_q  <= item.vbat_avg;
						vnow_q  <= item.vbat_now;
						iin_q   <= item.input_current;
						state_q <= S_FIN;
						case (item.op)
							OP_SAMPLE: begin
								if (!item.charging || item.cool_or_cold || item.demo_mode) begin
									have_q  <= 1'b0;
									step_q  <= '0;
									mode_q  <= MODE_CC;
									votes_q <= 1'b0;
									vm_q    <= VM_NONE;
									vvolt_q <= '0;
									vcurr_q <= '0;
								end else if (item.phm_active) begin
									state_q <= S_FIN;
								end else if (!have_q) begin
									if (n_steps != '0) begin
										addr_q  <= '0;
										phase_q <= PH_SCAN;
										state_q <= S_READ;
									end
								end else begin
									addr_q  <= step_q;
									phase_q <= cc_mode ? PH_VOLT : PH_CURR;
									state_q <= S_READ;
								end
							end
							OP_RESET: begin
								have_q  <= 1'b0;
								step_q  <= '0;
								mode_q  <= MODE_CC;
								votes_q <= 1'b0;
								vm_q    <= VM_NONE;
								vvolt_q <= '0;
								vcurr_q <= '0;
							end
							default: begin
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_READ: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					state_q <= S_FIN;
					case (phase_q)
						PH_SCAN: begin
							if (scan_more && gt) begin
								addr_q  <= addr_q + IdxW'(1);
								state_q <= S_READ;
							end else begin
								vm_q    <= VM_CC;
								votes_q <= 1'b1;
								vvolt_q <= fv;
								vcurr_q <= chg;
								have_q  <= 1'b1;
								step_q  <= addr_q;
								mode_q  <= MODE_CC;
							end
						end
						PH_VOLT: begin
							if (gt) begin
								mode_q <= MODE_CC;
							end else begin
								phase_q <= PH_CURR;
								state_q <= S_EVAL;
							end
						end
						PH_CURR: begin
							case (mode_q)
								MODE_CC, MODE_CC_ADJ: begin
									mode_q <= gt ? mode_q + 3'd1 : MODE_CC;
								end
								MODE_CV_CHECK: begin
									if (gt) begin
										vm_q <= VM_NONE;
										if (next_ok) begin
											addr_q  <= next_idx[IdxW-1:0];
											phase_q <= PH_CHOOSE;
											state_q <= S_READ;
										end
									end else begin
										vm_q   <= VM_CV;
										mode_q <= MODE_CV;
									end
								end
								MODE_CV_PRESET: begin
									vm_q   <= VM_CV;
									mode_q <= MODE_CV;
								end
								MODE_CV, MODE_CV_ADJ: begin
									mode_q <= gt ? mode_q + 3'd1 : MODE_CV;
								end
								MODE_CHANGE: begin
									vm_q <= VM_NONE;
									if (next_ok) begin
										addr_q  <= next_idx[IdxW-1:0];
										phase_q <= PH_CHOOSE;
										state_q <= S_READ;
									end
								end
								default: begin
									state_q <= S_FIN;
								end
							endcase
						end
						default: begin
							vm_q    <= VM_CC;
							votes_q <= 1'b1;
							vvolt_q <= fv;
							vcurr_q <= chg;
							have_q  <= 1'b1;
							step_q  <= addr_q;
							mode_q  <= MODE_CC;
						end
					endcase
				end
				default: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q           <= 1'b1;
						res_q.step_valid      <= have_q;
						res_q.step_index      <= step_q;
						res_q.mode            <= mode_q;
						res_q.charge_votes_on <= votes_q;
						res_q.voltage_vote    <= vvolt_q;
						res_q.current_vote    <= vcurr_q;
						res_q.vm_source       <= vm_q;
						state_q               <= S_IDLE;
					end
				end
			endcase
		end
	end

endmodule

// ===== tb/step_charge_mode_controller_tb.sv =====
// Self-checking testbench for the step-charging mode controller.
`timescale 1ns / 1ps
module step_charge_mode_controller_tb;
	import scmc_pkg::*;

	localparam logic [1:0] OP_UNKNOWN = 2'd3;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 24;
	localparam int STALL_LIMIT   = 5000;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [119:0] s_axis_tdata = '0;
	logic [1:0]   s_axis_tuser = OP_SAMPLE;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [47:0]  m_axis_tdata;
	logic         cfg_we = 1'b0;
	logic [0:0]   cfg_index = REG_STEP_COUNT;
	logic [9:0]   cfg_data = '0;

	step_charge_mode_controller dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	item_t pending_items[$];
	res_t  expected_state[$];
	item_t offered_item;
	logic  calm = 1'b0;
	int    hold_tokens = 0;
	int    mismatches = 0;

	// predicted controller state
	logic [63:0] ch_table [MaxSteps];
	logic        ch_have;
	logic [2:0]  ch_step;
	logic [2:0]  ch_mode;
	logic        ch_votes;
	logic [1:0]  ch_vm;
	logic [15:0] ch_vvolt;
	logic [15:0] ch_vcurr;
	logic [3:0]  ch_count;
	logic [9:0]  ch_gap;

	function automatic int steps_in_use();
		return (ch_count > MaxSteps) ? MaxSteps : int'(ch_count);
	endfunction

	function automatic logic [15:0] step_field(int idx, int which);
		if (idx >= MaxSteps)
			return '0;
		return ch_table[idx][16*which +: 16];
	endfunction

	function automatic void clear_charger();
		ch_have  = 1'b0;
		ch_step  = '0;
		ch_mode  = MODE_CC;
		ch_votes = 1'b0;
		ch_vm    = VM_NONE;
		ch_vvolt = '0;
		ch_vcurr = '0;
	endfunction

	function automatic void pick_step(int idx);
		if (idx >= steps_in_use())
			return;
		ch_vm    = VM_CC;
		ch_votes = 1'b1;
		ch_vvolt = step_field(idx, 0);
		ch_vcurr = step_field(idx, 1);
		ch_have  = 1'b1;
		ch_step  = idx[2:0];
		ch_mode  = MODE_CC;
	endfunction

	function automatic void apply_sample(item_t it);
		int idx;
		logic [15:0] fv, ccx, cvx;
		if (!it.charging || it.cool_or_cold || it.demo_mode) begin
			clear_charger();
			return;
		end
		if (it.phm_active)
			return;
		if (!ch_have) begin
			if (steps_in_use() == 0)
				return;
			idx = 0;
			while (idx + 1 < steps_in_use() && step_field(idx, 0) < it.vbat_avg)
				idx++;
			pick_step(idx);
			return;
		end
		fv  = step_field(ch_step, 0);
		ccx = step_field(ch_step, 2);
		cvx = step_field(ch_step, 3);
		case (ch_mode)
			MODE_CC, MODE_CC_ADJ: begin
				if (int'(fv) - int'(ch_gap) > int'(it.vbat_now))
					ch_mode = MODE_CC;
				else
					ch_mode = (ccx > it.input_current) ? ch_mode + 3'd1 : MODE_CC;
			end
			MODE_CV_CHECK: begin
				ch_vm = VM_NONE;
				if (cvx > it.input_current) begin
					pick_step(int'(ch_step) + 1);
				end else begin
					ch_vm   = VM_CV;
					ch_mode = MODE_CV;
				end
			end
			MODE_CV_PRESET: begin
				ch_vm   = VM_CV;
				ch_mode = MODE_CV;
			end
			MODE_CV, MODE_CV_ADJ: begin
				ch_mode = (cvx > it.input_current) ? ch_mode + 3'd1 : MODE_CV;
			end
			MODE_CHANGE: begin
				ch_vm = VM_NONE;
				pick_step(int'(ch_step) + 1);
			end
			default: ;
		endcase
	endfunction

	function automatic res_t advance_charger(item_t it);
		res_t r;
		case (it.op)
			OP_SAMPLE: apply_sample(it);
			OP_RESET:  clear_charger();
			OP_WRITE:  ch_table[it.entry_index] = it.entry_word;
			default: ;
		endcase
		r.step_valid      = ch_have;
		r.step_index      = ch_step;
		r.mode            = ch_mode;
		r.charge_votes_on = ch_votes;
		r.voltage_vote    = ch_votes ? ch_vvolt : '0;
		r.current_vote    = ch_votes ? ch_vcurr : '0;
		r.vm_source       = ch_vm;
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		$display("%0t ns: mismatch: %s", $time, what);
		mismatches++;
	endtask

	task automatic check_result(input logic [47:0] d);
		res_t want;
		if (expected_state.size() == 0) begin
			report_mismatch($sformatf("result %h with nothing expected", d));
			return;
		end
		want = expected_state.pop_front();
		if (d[0] !== want.step_valid)
			report_mismatch($sformatf("step_valid %b want %b", d[0], want.step_valid));
		if (d[3:1] !== want.step_index)
			report_mismatch($sformatf("step_index %0d want %0d", d[3:1], want.step_index));
		if (d[6:4] !== want.mode)
			report_mismatch($sformatf("mode %0d want %0d", d[6:4], want.mode));
		if (d[7] !== want.charge_votes_on)
			report_mismatch($sformatf("charge_votes_on %b want %b", d[7], want.charge_votes_on));
		if (d[23:8] !== want.voltage_vote)
			report_mismatch($sformatf("voltage_vote %0d want %0d", d[23:8], want.voltage_vote));
		if (d[39:24] !== want.current_vote)
			report_mismatch($sformatf("current_vote %0d want %0d", d[39:24], want.current_vote));
		if (d[41:40] !== want.vm_source)
			report_mismatch($sformatf("vm_source %0d want %0d", d[41:40], want.vm_source));
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				expected_state.push_back(advance_charger(offered_item));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_items.size() != 0 && (calm || $urandom_range(99) >= 14)) begin
					offered_item = pending_items.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tuser  <= offered_item.op;
					s_axis_tdata  <= {1'b0, offered_item.entry_word, offered_item.entry_index,
						offered_item.input_current, offered_item.vbat_now,
						offered_item.vbat_avg, offered_item.phm_active,
						offered_item.demo_mode, offered_item.cool_or_cold,
						offered_item.charging};
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver
	int hold_left = 0;
	int holds_done = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				check_result(m_axis_tdata);
			if (hold_left != 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (holds_done != hold_tokens) begin
				holds_done++;
				hold_left = HOLD_CYCLES;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= calm || ($urandom_range(99) >= 14);
			end
		end
	end

	int quiet_cycles = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= STALL_LIMIT) begin
					$display("** step_charge_mode_controller: FAILED **");
					$finish;
				end
			end
		end
	end

	function automatic logic [63:0] pack_entry(logic [15:0] volt, logic [15:0] chg,
		logic [15:0] cc_exit, logic [15:0] cv_exit);
		return {cv_exit, cc_exit, chg, volt};
	endfunction

	function automatic logic [63:0] random_entry();
		logic [15:0] volt, chg, cc_exit, cv_exit;
		if ($urandom_range(3) == 0)
			return {$urandom, $urandom};
		volt    = 16'($urandom_range(4500, 3000));
		chg     = 16'($urandom);
		cc_exit = 16'($urandom_range(1500, 200));
		cv_exit = 16'($urandom_range(1000, 100));
		return pack_entry(volt, chg, cc_exit, cv_exit);
	endfunction

	function automatic item_t table_write(logic [2:0] idx, logic [63:0] word);
		item_t it;
		it = '0;
		it.op          = OP_WRITE;
		it.entry_index = idx;
		it.entry_word  = word;
		return it;
	endfunction

	function automatic item_t good_sample(logic [15:0] vavg, logic [15:0] vnow,
		logic [15:0] iin);
		item_t it;
		it = '0;
		it.op            = OP_SAMPLE;
		it.charging      = 1'b1;
		it.vbat_avg      = vavg;
		it.vbat_now      = vnow;
		it.input_current = iin;
		return it;
	endfunction

	function automatic item_t random_item();
		item_t it;
		int r;
		r = $urandom_range(99);
		{it.charging, it.cool_or_cold, it.demo_mode, it.phm_active} = 4'($urandom_range(15));
		it.vbat_avg      = 16'($urandom);
		it.vbat_now      = 16'($urandom);
		it.input_current = 16'($urandom);
		it.entry_index   = 3'($urandom_range(7));
		it.entry_word    = {$urandom, $urandom};
		if (r < 4) begin
			it.op = OP_RESET;
		end else if (r < 6) begin
			it.op = OP_UNKNOWN;
		end else if (r < 12) begin
			it.op = OP_WRITE;
			it.entry_word = random_entry();
		end else begin
			it.op = OP_SAMPLE;
			if (r < 17) begin
				if (it.charging && !it.cool_or_cold && !it.demo_mode)
					it.cool_or_cold = 1'b1;
			end else begin
				it.charging     = 1'b1;
				it.cool_or_cold = 1'b0;
				it.demo_mode    = 1'b0;
				it.phm_active   = (r < 23);
				if ($urandom_range(9) < 7)
					it.vbat_avg = 16'($urandom_range(4600, 2900));
				case ($urandom_range(9))
					0, 1, 2, 3, 4, 5: it.vbat_now = 16'($urandom_range(4800, 4300));
					6, 7:             it.vbat_now = 16'($urandom_range(4300, 2500));
					default: ;
				endcase
				if ($urandom_range(1) == 0)
					it.input_current = 16'($urandom_range(1200, 0));
			end
		end
		return it;
	endfunction

	task automatic load_directed();
		item_t it;
		pending_items.push_back(table_write(3'd0, pack_entry(16'd4000, 16'd1500, 16'd500, 16'd300)));
		for (int i = 1; i < 6; i++)
			pending_items.push_back(table_write(i[2:0], pack_entry(16'(4100 + 50 * i),
				16'd1000, 16'd400, 16'd200)));
		pending_items.push_back(table_write(3'd6, 64'h0));
		pending_items.push_back(table_write(3'd7, {64{1'b1}}));
		// walk all reachable modes on a single step, then fail to move on
		pending_items.push_back(good_sample(16'd0, 16'd0, 16'd0));
		pending_items.push_back(good_sample(16'd0, 16'd0, 16'd0));
		pending_items.push_back(good_sample(16'd0, 16'hFFFF, 16'd0));
		pending_items.push_back(good_sample(16'd0, 16'hFFFF, 16'd0));
		pending_items.push_back(good_sample(16'hFFFF, 16'hFFFF, 16'hFFFF));
		pending_items.push_back(good_sample(16'd0, 16'd0, 16'd0));
		pending_items.push_back(good_sample(16'd0, 16'd0, 16'd0));
		pending_items.push_back(good_sample(16'd0, 16'd0, 16'd0));
		it = good_sample(16'd0, 16'd0, 16'd0);
		it.phm_active = 1'b1;
		pending_items.push_back(it);
		it.op = OP_UNKNOWN;
		pending_items.push_back(it);
		// rewrite the held entry; target below the gap makes the compare negative
		pending_items.push_back(table_write(3'd0, pack_entry(16'd10, 16'd700, 16'd500, 16'd300)));
		it = good_sample(16'd0, 16'd0, 16'd0);
		it.charging = 1'b0;
		pending_items.push_back(it);
		pending_items.push_back(good_sample(16'hFFFF, 16'd0, 16'd0));
		pending_items.push_back(good_sample(16'd0, 16'd0, 16'd0));
		it = good_sample(16'd0, 16'd0, 16'd0);
		it.cool_or_cold = 1'b1;
		pending_items.push_back(it);
		pending_items.push_back(good_sample(16'd0, 16'd0, 16'd0));
		it.op = OP_RESET;
		pending_items.push_back(it);
		it = good_sample(16'd0, 16'd0, 16'd0);
		it.demo_mode = 1'b1;
		pending_items.push_back(it);
	endtask

	task automatic wait_quiet();
		do
			@(negedge clk);
		while (pending_items.size() != 0 || s_axis_tvalid || expected_state.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic run_phase(input logic [3:0] count, input logic [9:0] gap, input int n,
		input logic quiet, input logic hold);
		wait_quiet();
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_STEP_COUNT;
		cfg_data  <= {6'd0, count};
		ch_count   = count;
		@(posedge clk);
		cfg_index <= REG_VOLT_GAP;
		cfg_data  <= gap;
		ch_gap     = gap;
		@(posedge clk);
		cfg_we    <= 1'b0;
		calm      <= quiet;
		@(negedge clk);
		if (hold)
			hold_tokens++;
		repeat (n) pending_items.push_back(random_item());
	endtask

	initial begin
		logic [9:0] gap_pick;
		for (int i = 0; i < MaxSteps; i++)
			ch_table[i] = '0;
		ch_count = 4'd1;
		ch_gap   = 10'd25;
		clear_charger();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		load_directed();
		run_phase(4'd8, 10'd25, 150, 1'b1, 1'b0);
		run_phase(4'd15, 10'd1023, 150, 1'b0, 1'b1);
		run_phase(4'd0, 10'd0, 80, 1'b0, 1'b0);
		run_phase(4'd3, 10'd500, 150, 1'b0, 1'b0);
		gap_pick = 10'($urandom_range(1023));
		run_phase(4'd9, gap_pick, 150, 1'b0, 1'b0);
		run_phase(4'd1, 10'd1023, 80, 1'b0, 1'b0);
		run_phase(4'd8, 10'd0, 120, 1'b0, 1'b0);
		wait_quiet();
		if (mismatches == 0)
			$display("** step_charge_mode_controller: PASSED **");
		else
			$display("** step_charge_mode_controller: FAILED **");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/scmc_pkg.sv
rtl/core/scmc_table.sv
rtl/core/scmc_ctrl.sv
rtl/core/step_charge_mode_controller.sv
tb/step_charge_mode_controller_tb.sv
